// ===== hdl/vtdi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtdi_pkg
// Shared types and constants of the vertex tuple dedup indexer.
// ----------------------------------------------------------------------------
package vtdi_pkg;

   localparam int MAX_VERTS = 1024;
   localparam int MAX_WORDS = 8;
   localparam int WORD_W    = 24;
   localparam int INDEX_W   = $clog2(MAX_VERTS);
   localparam int COUNT_W   = $clog2(MAX_VERTS + 1);
   localparam int WIU_W     = 4;

   localparam logic [WIU_W-1:0] WIU_RESET = 4'd4;
   localparam logic             OP_CLEAR  = 1'b0;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [MAX_WORDS-1:0] row_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic take_hit;
      logic mark_full;
      logic insert;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_req;
      logic hit;
      logic scan_done;
      logic is_full;
   } ctl_status_type;

endpackage
`default_nettype wire

// ===== hdl/vtdi_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtdi_datapath
// Tuple table, entry count, scan pipeline, result and output registers.
// ----------------------------------------------------------------------------
module vtdi_datapath
   import vtdi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctl_cmd_type          cmd,
   output ctl_status_type            status,
   input  wire logic                 req_opcode,
   input  wire row_type              req_key,
   input  wire logic                 csr_write_enable,
   input  wire logic [WIU_W-1:0]     csr_write_data,
   output logic [INDEX_W-1:0]        rsp_vertex_index,
   output logic                      rsp_was_inserted,
   output logic                      rsp_table_full,
   output logic [COUNT_W-1:0]        rsp_vertex_count
);

   row_type              mem [MAX_VERTS];
   row_type              rd_row_ff;
   logic [INDEX_W-1:0]   tag_ff;

   row_type              key_ff, key_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WIU_W-1:0]     words_ff, words_in;
   logic [COUNT_W-1:0]   issue_ff, issue_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [INDEX_W-1:0]   res_index_ff, res_index_in;
   logic                 res_ins_ff, res_ins_in;
   logic                 res_full_ff, res_full_in;
   logic [INDEX_W-1:0]   out_index_ff, out_index_in;
   logic                 out_ins_ff, out_ins_in;
   logic                 out_full_ff, out_full_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;

   logic [WIU_W-1:0]     n_eff;
   logic                 more_rows;
   logic                 row_match;

   // clamp the word count to 1..MAX_WORDS
   always_comb begin
      if (words_ff == '0) begin
         n_eff = WIU_W'(1);
      end else if (words_ff > WIU_W'(MAX_WORDS)) begin
         n_eff = WIU_W'(MAX_WORDS);
      end else begin
         n_eff = words_ff;
      end
   end

   always_comb begin
      row_match = 1'b1;
      for (int w = 0; w < MAX_WORDS; w++) begin
         if (WIU_W'(w) < n_eff && rd_row_ff[w] != key_ff[w]) begin
            row_match = 1'b0;
         end
      end
   end

   assign more_rows = issue_ff < count_ff;

   assign status.clear_req = (req_opcode == OP_CLEAR);
   assign status.hit       = cmp_valid_ff & row_match;
   assign status.scan_done = !more_rows && !cmp_valid_ff;
   assign status.is_full   = count_ff >= COUNT_W'(MAX_VERTS);

   always_comb begin
      key_in       = cmd.accept ? req_key : key_ff;
      words_in     = csr_write_enable ? csr_write_data : words_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmd.scan && more_rows;
      count_in     = count_ff;
      res_index_in = res_index_ff;
      res_ins_in   = res_ins_ff;
      res_full_in  = res_full_ff;

      if (cmd.accept) begin
         issue_in = '0;
      end else if (cmd.scan && more_rows) begin
         issue_in = issue_ff + COUNT_W'(1);
      end

      if (cmd.accept && status.clear_req) begin
         count_in     = '0;
         res_index_in = '0;
         res_ins_in   = 1'b0;
         res_full_in  = 1'b0;
      end else if (cmd.take_hit) begin
         res_index_in = tag_ff;
         res_ins_in   = 1'b0;
         res_full_in  = 1'b0;
      end else if (cmd.mark_full) begin
         res_index_in = '0;
         res_ins_in   = 1'b0;
         res_full_in  = 1'b1;
      end else if (cmd.insert) begin
         count_in     = count_ff + COUNT_W'(1);
         res_index_in = count_ff[INDEX_W-1:0];
         res_ins_in   = 1'b1;
         res_full_in  = 1'b0;
      end

      out_index_in = out_index_ff;
      out_ins_in   = out_ins_ff;
      out_full_in  = out_full_ff;
      out_count_in = out_count_ff;
      if (cmd.load_out) begin
         out_index_in = res_index_ff;
         out_ins_in   = res_ins_ff;
         out_full_in  = res_full_ff;
         out_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         mem[count_ff[INDEX_W-1:0]] <= key_ff;
      end
      rd_row_ff <= mem[issue_ff[INDEX_W-1:0]];
      tag_ff    <= issue_ff[INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         words_ff     <= WIU_RESET;
         cmp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         words_ff     <= words_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      issue_ff     <= issue_in;
      res_index_ff <= res_index_in;
      res_ins_ff   <= res_ins_in;
      res_full_ff  <= res_full_in;
      out_index_ff <= out_index_in;
      out_ins_ff   <= out_ins_in;
      out_full_ff  <= out_full_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_vertex_index = out_index_ff;
   assign rsp_was_inserted = out_ins_ff;
   assign rsp_table_full   = out_full_ff;
   assign rsp_vertex_count = out_count_ff;

endmodule
`default_nettype wire

// ===== hdl/vtdi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtdi_ctrl
// Sequencer: accept, scan, settle the result and hand it to the output.
// ----------------------------------------------------------------------------
module vtdi_ctrl
   import vtdi_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.clear_req ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_DONE;
            end else if (status.scan_done) begin
               if (status.is_full) begin
                  cmd.mark_full = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = cmd.load_out || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/vertex_tuple_dedup_indexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_indexer
// Welds mesh corners: gives each distinct tuple of index words one index.
// ----------------------------------------------------------------------------
// Usage
//   req_*: one item per handshake, opcode 0 clears the table, opcode 1
//   looks up or appends the tuple in req_key_word_0..7. rsp_*: one item
//   per request with the vertex index, insert and full flags and the
//   vertex count. csr_*: write words_in_use (compared words) while idle.
// Timing
//   One item at a time; the next item is taken only after its
//   predecessor's result has been loaded into the output register. A
//   clear skips the scan; a lookup scans the stored rows in order and
//   stops at the earliest match, or after every stored row on a miss,
//   then appends the tuple unless the table is full. The table RAM
//   streams one stored row per cycle to the compare.
// Reset
//   Empties the table and sets words_in_use to 4. No clearing pass.
// Stall
//   A stalled result holds in the output register; the block still takes
//   and processes the next item, then waits until the output frees.
// ----------------------------------------------------------------------------
module vertex_tuple_dedup_indexer
   import vtdi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_opcode,
   input  wire logic [WORD_W-1:0]  req_key_word_0,
   input  wire logic [WORD_W-1:0]  req_key_word_1,
   input  wire logic [WORD_W-1:0]  req_key_word_2,
   input  wire logic [WORD_W-1:0]  req_key_word_3,
   input  wire logic [WORD_W-1:0]  req_key_word_4,
   input  wire logic [WORD_W-1:0]  req_key_word_5,
   input  wire logic [WORD_W-1:0]  req_key_word_6,
   input  wire logic [WORD_W-1:0]  req_key_word_7,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [INDEX_W-1:0]      rsp_vertex_index,
   output logic                    rsp_was_inserted,
   output logic                    rsp_table_full,
   output logic [COUNT_W-1:0]      rsp_vertex_count,
   input  wire logic               csr_write_enable,
   input  wire logic [WIU_W-1:0]   csr_write_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;
   row_type        req_key;

   assign req_key[0] = req_key_word_0;
   assign req_key[1] = req_key_word_1;
   assign req_key[2] = req_key_word_2;
   assign req_key[3] = req_key_word_3;
   assign req_key[4] = req_key_word_4;
   assign req_key[5] = req_key_word_5;
   assign req_key[6] = req_key_word_6;
   assign req_key[7] = req_key_word_7;

   vtdi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vtdi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_was_inserted (rsp_was_inserted),
      .rsp_table_full   (rsp_table_full),
      .rsp_vertex_count (rsp_vertex_count)
   );

endmodule
`default_nettype wire
